// ===== rtl/core/meeting_room_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// Meeting room allocator assertion macros
// Concurrent assertion wrappers used by the allocator datapath. They compile to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MEETING_ROOM_ALLOCATOR_TOP_ASSERT_SVH
`define MEETING_ROOM_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define MRA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed in %m");
// Condition must never be true at a clock edge outside reset.
`define MRA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen in %m");
`else
`define MRA_ASSERT(lbl, clk, rst_n, prop)
`define MRA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/mra_pkg.sv =====
// ----------------------------------------------------------------------------
// Meeting room allocator package
// Sizes, item types, controller/datapath interface types and helper functions.
// ----------------------------------------------------------------------------
package mra_pkg;

	// Built room count and width of the stored finish times.
	localparam int ROOMS     = 16;
	localparam int TIME_BITS = 48;

	// Fixed field widths of the item types.
	localparam int IN_TIME_W  = 32;
	localparam int OUT_TIME_W = 48;
	localparam int ROOM_W     = 4;
	localparam int USES_W     = 32;
	localparam int CFG_W      = 5;

	// Derived widths: room index, room count, and compare width for the output clamp.
	localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
	localparam int CNT_W = $clog2(ROOMS + 1);
	localparam int CMP_W = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

	localparam logic [CFG_W-1:0]  ROOM_COUNT_RST = CFG_W'(16);
	localparam logic [CMP_W-1:0]  OUT_TIME_MAX   = CMP_W'({OUT_TIME_W{1'b1}});

	typedef struct packed {
		logic [IN_TIME_W-1:0] start_time;
		logic [IN_TIME_W-1:0] end_time;
		logic                 final_meeting;
	} in_item_t;

	typedef struct packed {
		logic [ROOM_W-1:0]     room;
		logic [OUT_TIME_W-1:0] finish_time;
		logic                  was_delayed;
		logic [ROOM_W-1:0]     most_booked;
		logic                  batch_done;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic update;
		logic emit;
	} mra_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic slot_free;
	} mra_sts_t;

	// Room count in effect: zero acts as one, anything above ROOMS acts as ROOMS.
	function automatic logic [CNT_W-1:0] rooms_in_use(input logic [CFG_W-1:0] rc);
		int c;
		c = int'(rc);
		if (c == 0) begin
			c = 1;
		end else if (c > ROOMS) begin
			c = ROOMS;
		end
		return CNT_W'(c);
	endfunction

	// Low bits of a room index for the narrow result fields.
	function automatic logic [ROOM_W-1:0] room_field(input logic [IDX_W-1:0] idx);
		logic [IDX_W+ROOM_W-1:0] wide;
		wide = (IDX_W + ROOM_W)'(idx);
		return wide[ROOM_W-1:0];
	endfunction

	// Clamp a stored finish time to the result field.
	function automatic logic [OUT_TIME_W-1:0] out_time(input logic [TIME_BITS-1:0] t);
		logic [CMP_W-1:0] w;
		w = CMP_W'(t);
		if (w > OUT_TIME_MAX) begin
			w = OUT_TIME_MAX;
		end
		return w[OUT_TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/core/mra_ctrl.sv =====
// ----------------------------------------------------------------------------
// Meeting room allocator controller
// Sequences one meeting at a time: load, room scan, update, result hand-off.
// ----------------------------------------------------------------------------
module mra_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  mra_pkg::mra_sts_t sts,
	output mra_pkg::mra_cmd_t cmd
);
	import mra_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A new item is taken only between meetings.
	assign in_stall = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/mra_dpath.sv =====
// ----------------------------------------------------------------------------
// Meeting room allocator datapath
// Room tables, the per-room scan, finish time arithmetic, most-booked tracking
// and the output register.
// ----------------------------------------------------------------------------
`include "meeting_room_allocator_top_assert.svh"

module mra_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mra_pkg::CFG_W-1:0]   cfg_wr_data,
	input  mra_pkg::in_item_t           in_item,
	input  mra_pkg::mra_cmd_t           cmd,
	output mra_pkg::mra_sts_t           sts,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mra_pkg::out_item_t          out_item
);
	import mra_pkg::*;

	// Configuration and the latched meeting.
	logic [CFG_W-1:0]     room_count_q;
	logic [IN_TIME_W-1:0] start_q;
	logic [IN_TIME_W-1:0] end_q;
	logic                 final_q;

	// Room tables.
	logic [TIME_BITS-1:0] finish_q [ROOMS];
	logic                 busy_q   [ROOMS];
	logic [USES_W-1:0]    uses_q   [ROOMS];

	// Scan state.
	logic [IDX_W-1:0]     idx_q;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [USES_W-1:0]    pick_uses_q;
	logic [TIME_BITS-1:0] min_fin_q;
	logic [IDX_W-1:0]     min_idx_q;
	logic [USES_W-1:0]    min_uses_q;

	// Most-booked tracking: index and a copy of its count.
	logic [IDX_W-1:0]     best_q;
	logic [USES_W-1:0]    best_uses_q;

	// Pending result and output register.
	out_item_t            res_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	logic [CNT_W-1:0]     n_eff;
	logic [TIME_BITS-1:0] start_ext;
	logic [TIME_BITS-1:0] fin_i;
	logic                 busy_now;
	logic                 take_min;
	logic [IDX_W-1:0]     chosen;
	logic [USES_W-1:0]    uses_old;
	logic [USES_W-1:0]    uses_new;
	logic [IN_TIME_W-1:0] dur;
	logic [TIME_BITS:0]   fin_sum;
	logic [TIME_BITS-1:0] new_fin;
	logic                 best_take;
	logic [IDX_W-1:0]     next_best;

	assign n_eff     = rooms_in_use(room_count_q);
	assign start_ext = TIME_BITS'(start_q);

	// Scan step at the current room: free it if done, then test for the earliest finish.
	assign fin_i    = finish_q[idx_q];
	assign busy_now = busy_q[idx_q] && !(fin_i <= start_ext);
	assign take_min = (idx_q == '0) || (fin_i < min_fin_q);

	assign sts.scan_last = (CNT_W'(idx_q) == (n_eff - CNT_W'(1)));
	assign sts.slot_free = !out_valid_q || !out_stall;

	// Room choice and finish time; a delayed meeting keeps its duration and saturates.
	assign chosen   = found_q ? pick_q : min_idx_q;
	assign uses_old = found_q ? pick_uses_q : min_uses_q;
	assign uses_new = (uses_old == '1) ? uses_old : uses_old + 1'b1;
	assign dur      = (end_q > start_q) ? (end_q - start_q) : '0;
	assign fin_sum  = {1'b0, min_fin_q} + (TIME_BITS + 1)'(dur);
	assign new_fin  = found_q ? TIME_BITS'(end_q) :
		(fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0]);

	// Only the chosen room's count grows, so the leader changes only to it.
	assign best_take = (chosen != best_q) && ((uses_new > best_uses_q) ||
		((uses_new == best_uses_q) && (chosen < best_q)));
	assign next_best = best_take ? chosen : best_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= ROOM_COUNT_RST;
		end else if (cfg_wr_en) begin
			room_count_q <= cfg_wr_data;
		end
	end

	// Meeting capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= in_item.start_time;
			end_q   <= in_item.end_time;
			final_q <= in_item.final_meeting;
		end
	end

	// Scan counter and candidate tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.load) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (!busy_now && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (!busy_now && !found_q) begin
				pick_q      <= idx_q;
				pick_uses_q <= uses_q[idx_q];
			end
			if (take_min) begin
				min_fin_q  <= fin_i;
				min_idx_q  <= idx_q;
				min_uses_q <= uses_q[idx_q];
			end
		end
	end

	// Room tables: freed during the scan, booked on update, cleared after a final meeting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOMS; k++) begin
				finish_q[k] <= '0;
				busy_q[k]   <= 1'b0;
				uses_q[k]   <= '0;
			end
		end else if (cmd.emit && res_q.batch_done) begin
			for (int k = 0; k < ROOMS; k++) begin
				finish_q[k] <= '0;
				busy_q[k]   <= 1'b0;
				uses_q[k]   <= '0;
			end
		end else if (cmd.scan) begin
			busy_q[idx_q] <= busy_now;
		end else if (cmd.update) begin
			finish_q[chosen] <= new_fin;
			busy_q[chosen]   <= 1'b1;
			uses_q[chosen]   <= uses_new;
		end
	end

	// Most-booked room.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '0;
			best_uses_q <= '0;
		end else if (cmd.emit && res_q.batch_done) begin
			best_q      <= '0;
			best_uses_q <= '0;
		end else if (cmd.update) begin
			if (chosen == best_q) begin
				best_uses_q <= uses_new;
			end else if (best_take) begin
				best_q      <= chosen;
				best_uses_q <= uses_new;
			end
		end
	end

	// Pending result, built on update.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q.room        <= room_field(chosen);
			res_q.finish_time <= out_time(new_fin);
			res_q.was_delayed <= !found_q;
			res_q.most_booked <= room_field(next_best);
			res_q.batch_done  <= final_q;
		end
	end

	// Output register: holds a result until the receiver takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The tracked leader count always matches the table.
	`MRA_ASSERT(a_best_uses_match, clk, arst_n, best_uses_q == uses_q[best_q])
	// The scan never touches a room outside the count in effect.
	`MRA_ASSERT_NEVER(a_scan_in_range, clk, arst_n, cmd.scan && (CNT_W'(idx_q) >= n_eff))
	// The booked room is marked busy right after the update.
	`MRA_ASSERT(a_booked_busy, clk, arst_n, cmd.update |=> busy_q[$past(chosen)])
	// A result never overwrites one still waiting at the output.
	`MRA_ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && out_valid_q && out_stall)

endmodule

// ===== rtl/core/meeting_room_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Meeting room allocator top level
// Assigns meetings, given in nondecreasing start order, to the lowest free
// room, or delays them into the room that frees up first.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (start_time, end_time, final_meeting) enter on in_valid and
//   are taken at an edge where in_stall is low. One result item (room,
//   finish_time, was_delayed, most_booked, batch_done) leaves per input on
//   out_valid and is taken where out_stall is low.
//   One meeting is in flight at a time. After the edge that takes its item,
//   the block scans the rooms in effect, freeing rooms and picking the free or
//   earliest-finishing room, then updates the room tables and then hands the
//   result to the output register once that register is free. The next item
//   is accepted in the cycle after the hand-off, so the block takes no new
//   item before it has handed off the last one.
//   If the receiver stalls, the result waits in the output register while the
//   next item is already processed; that item then waits for the register.
//   Reset frees all rooms, clears the counts and sets the room count to 16.
//   A final meeting frees all rooms and clears the counts as its result is handed off; the room count is kept.
//   cfg_wr_en writes the room count; write it only while the block is idle.
// ----------------------------------------------------------------------------
module meeting_room_allocator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [mra_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  mra_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output mra_pkg::out_item_t        out_item
);
	import mra_pkg::*;

	mra_cmd_t cmd;
	mra_sts_t sts;

	// Sequencer.
	mra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Room tables and arithmetic.
	mra_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_item     (in_item),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

// ===== tb/meeting_room_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// Meeting room allocator testbench
// Drives meetings into the allocator through the valid/stall handshake and
// checks every result item against a cycle-free model of the room scan kept
// here. Directed tests cover the field extremes, delays, ties, the room count
// limits and a delayed finish time that grows past the 32-bit range; random
// traffic then runs under changing room counts and varying sender and
// receiver idling.
// ----------------------------------------------------------------------------
module meeting_room_allocator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mra_pkg::*;

	localparam logic [63:0] FINISH_MAX = (64'd1 << TIME_BITS) - 64'd1;
	localparam logic [31:0] USES_MAX   = 32'hFFFF_FFFF;
	localparam logic [31:0] TIME_TOP   = 32'hFFFF_FFFF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;

	// Model state of the rooms and the room count register.
	logic [TIME_BITS-1:0] room_end   [ROOMS];
	logic                 room_taken [ROOMS];
	logic [USES_W-1:0]    room_books [ROOMS];
	logic [CFG_W-1:0]     rooms_setting;

	out_item_t awaited_bookings [$];
	out_item_t booking_want;
	int        mismatch_count = 0;
	int        sender_idle_pct = 0;
	int        receiver_idle_pct = 0;

	meeting_room_allocator_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

	// Free-running clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Receiver stalls at random at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	// Frees every room and clears the use counts; the room count is kept.
	function automatic void clear_rooms();
		for (int i = 0; i < ROOMS; i++) begin
			room_end[i] = '0;
			room_taken[i] = 1'b0;
			room_books[i] = '0;
		end
	endfunction

	// Books one meeting into the model rooms and returns the result it gives.
	function automatic out_item_t allocate_meeting(input in_item_t m);
		out_item_t   r;
		int          n;
		int          pick;
		int          best;
		bit          found;
		logic [63:0] dur;
		logic [63:0] fin;
		if (rooms_setting == 0) begin
			n = 1;
		end else if (rooms_setting > ROOMS) begin
			n = ROOMS;
		end else begin
			n = int'(rooms_setting);
		end
		r = '0;
		found = 1'b0;
		pick = 0;

		// Free the rooms whose meetings are over by the start.
		for (int i = 0; i < n; i++) begin
			if (room_taken[i] && room_end[i] <= TIME_BITS'(m.start_time)) begin
				room_taken[i] = 1'b0;
			end
		end

		// Lowest free room first; otherwise the earliest finish, lowest index on ties.
		for (int i = 0; i < n; i++) begin
			if (!found && !room_taken[i]) begin
				pick = i;
				found = 1'b1;
			end
		end
		if (found) begin
			fin = 64'(m.end_time);
		end else begin
			dur = (m.end_time > m.start_time) ? 64'(m.end_time) - 64'(m.start_time) : 64'd0;
			pick = 0;
			for (int i = 1; i < n; i++) begin
				if (room_end[i] < room_end[pick]) begin
					pick = i;
				end
			end
			fin = 64'(room_end[pick]) + dur;
			if (fin > FINISH_MAX) begin
				fin = FINISH_MAX;
			end
			r.was_delayed = 1'b1;
		end

		room_end[pick] = fin[TIME_BITS-1:0];
		room_taken[pick] = 1'b1;
		if (room_books[pick] != USES_MAX) begin
			room_books[pick] = room_books[pick] + 1;
		end

		// Most-booked room counts every room, in use or not.
		best = 0;
		for (int i = 1; i < ROOMS; i++) begin
			if (room_books[i] > room_books[best]) begin
				best = i;
			end
		end

		r.room = pick[ROOM_W-1:0];
		r.finish_time = fin[OUT_TIME_W-1:0];
		r.most_booked = best[ROOM_W-1:0];
		r.batch_done = m.final_meeting;
		if (m.final_meeting) begin
			clear_rooms();
		end
		return r;
	endfunction

	// Adds a span to a time, held at the top of the 32-bit range.
	function automatic logic [31:0] later_by(input logic [31:0] t, input logic [31:0] d);
		logic [32:0] s;
		s = {1'b0, t} + {1'b0, d};
		return s[32] ? TIME_TOP : s[31:0];
	endfunction

	function automatic in_item_t meeting(input logic [31:0] s, input logic [31:0] e,
			input logic last);
		in_item_t m;
		m.start_time = s;
		m.end_time = e;
		m.final_meeting = last;
		return m;
	endfunction

	// Mostly small counts so the delays come often; now and then the limits.
	function automatic logic [CFG_W-1:0] pick_room_count();
		case ($urandom_range(9))
			0, 1, 2, 3: return CFG_W'($urandom_range(1, 4));
			4:          return '0;
			5:          return CFG_W'($urandom_range(17, 31));
			6, 7:       return CFG_W'(ROOMS);
			default:    return CFG_W'($urandom_range(5, 15));
		endcase
	endfunction

	// Reports one field that differs from the expected result.
	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Results are checked at the falling edge before the edge that takes them.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_bookings.size() == 0) begin
				$error("result item with no meeting outstanding: room %0d finish %0d",
					out_item.room, out_item.finish_time);
				mismatch_count++;
			end else begin
				booking_want = awaited_bookings.pop_front();
				compare_field("room", 64'(booking_want.room), 64'(out_item.room));
				compare_field("finish_time", 64'(booking_want.finish_time),
					64'(out_item.finish_time));
				compare_field("was_delayed", 64'(booking_want.was_delayed),
					64'(out_item.was_delayed));
				compare_field("most_booked", 64'(booking_want.most_booked),
					64'(out_item.most_booked));
				compare_field("batch_done", 64'(booking_want.batch_done),
					64'(out_item.batch_done));
			end
		end
	end

	// Sends one meeting, after a random gap, and books it in the model once taken.
	task automatic offer_meeting(input in_item_t m);
		bit taken;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= m;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		awaited_bookings.push_back(allocate_meeting(m));
	endtask

	// Holds the sender off until every booked meeting has come back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (awaited_bookings.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes the room count once the block has gone idle.
	task automatic set_rooms(input logic [CFG_W-1:0] count);
		wait_for_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rooms_setting = count;
	endtask

	// Field extremes with the room count left at its reset value.
	task automatic test_reset_extremes();
		offer_meeting(meeting(32'd0, 32'd0, 1'b0));
		offer_meeting(meeting(32'd0, TIME_TOP, 1'b0));
		offer_meeting(meeting(32'd0, 32'd1, 1'b0));
		offer_meeting(meeting(32'd1, 32'd1, 1'b0));
		offer_meeting(meeting(TIME_TOP, TIME_TOP, 1'b0));
		offer_meeting(meeting(TIME_TOP, 32'd0, 1'b1));
	endtask

	// Two rooms: delays, an end not after its start, and ties on the finish time.
	task automatic test_delays_and_ties();
		set_rooms(CFG_W'(2));
		offer_meeting(meeting(32'd10, 32'd100, 1'b0));
		offer_meeting(meeting(32'd10, 32'd60, 1'b0));
		offer_meeting(meeting(32'd20, 32'd50, 1'b0));
		offer_meeting(meeting(32'd20, 32'd20, 1'b0));
		offer_meeting(meeting(32'd30, 32'd25, 1'b0));
		offer_meeting(meeting(32'd100, 32'd150, 1'b0));
		offer_meeting(meeting(32'd100, 32'd150, 1'b0));
		offer_meeting(meeting(32'd110, 32'd120, 1'b0));
		offer_meeting(meeting(32'd200, 32'd210, 1'b1));
	endtask

	// A zero count acts as one room and a count past the built rooms as all of them.
	task automatic test_count_limits();
		set_rooms('0);
		offer_meeting(meeting(32'd0, 32'd5, 1'b0));
		offer_meeting(meeting(32'd0, 32'd5, 1'b0));
		offer_meeting(meeting(32'd3, 32'd4, 1'b1));
		set_rooms('1);
		offer_meeting(meeting(32'd7, 32'd9, 1'b0));
		offer_meeting(meeting(32'd7, 32'd9, 1'b0));
		offer_meeting(meeting(32'd8, 32'd30, 1'b0));
	endtask

	// One room, full-length meetings all at zero: the delayed finish climbs far
	// past the 32-bit range.
	task automatic test_finish_saturation();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		set_rooms(CFG_W'(1));
		for (int k = 0; k < 40; k++) begin
			offer_meeting(meeting(32'd0, TIME_TOP, k == 39));
		end
	endtask

	// Random batches of ordered meetings with some noise, under the given idling.
	task automatic test_random_batches(input int tx_pct, input int rx_pct, input int meetings);
		int          sent;
		int          batch_len;
		bit          tidy;
		logic [31:0] step_max;
		logic [31:0] dur_max;
		logic [31:0] t;
		in_item_t    m;
		sender_idle_pct = tx_pct;
		receiver_idle_pct = rx_pct;
		sent = 0;
		while (sent < meetings) begin
			if ($urandom_range(99) < 40) begin
				set_rooms(pick_room_count());
			end else if ($urandom_range(9) == 0) begin
				wait_for_results();
			end
			tidy = ($urandom_range(99) < 85);
			batch_len = $urandom_range(1, 40);
			step_max = ($urandom_range(3) == 0) ? 32'd200 : 32'd15;
			dur_max = ($urandom_range(3) == 0) ? 32'd1000 : 32'd60;
			t = ($urandom_range(7) == 0) ? TIME_TOP - $urandom_range(5000) : $urandom_range(100);
			for (int k = 0; k < batch_len; k++) begin
				if (tidy) begin
					t = later_by(t, $urandom_range(step_max));
					m.start_time = t;
					if ($urandom_range(19) == 0) begin
						m.end_time = t - $urandom_range(3);
					end else begin
						m.end_time = later_by(t, $urandom_range(1, dur_max));
					end
					m.final_meeting = (k == batch_len - 1) && ($urandom_range(99) < 80);
				end else begin
					m.start_time = $urandom();
					m.end_time = $urandom();
					m.final_meeting = ($urandom_range(9) == 0);
				end
				offer_meeting(m);
				sent++;
			end
		end
	endtask

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("meeting_room_allocator_top: mismatch");
		$finish;
	end

	initial begin
		int guard;
		clear_rooms();
		rooms_setting = ROOM_COUNT_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_extremes();
		test_delays_and_ties();
		test_count_limits();
		test_finish_saturation();
		test_random_batches(28, 46, 500);
		test_random_batches(46, 28, 500);
		test_random_batches(0, 0, 500);

		// Drain the last results, then watch for strays.
		in_valid <= 1'b0;
		for (guard = 0; awaited_bookings.size() != 0 && guard < 200000; guard++) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (awaited_bookings.size() != 0) begin
			$error("%0d result items never arrived", awaited_bookings.size());
			mismatch_count++;
		end

		if (mismatch_count == 0) begin
			$display("meeting_room_allocator_top: match");
		end else begin
			$display("meeting_room_allocator_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mra_pkg.sv
rtl/core/mra_ctrl.sv
rtl/core/mra_dpath.sv
rtl/core/meeting_room_allocator_top.sv
tb/meeting_room_allocator_top_test.sv
